### sv/ifb_pkg.sv
// Shared types and constants of the IPv4 frame builder.
package ifb_pkg;

    // Fixed frame layout.
    localparam int unsigned HDR_BYTES    = 34;
    localparam int unsigned IP_HDR_BYTES = 20;
    localparam int unsigned SUM_W        = 20;

    // Command queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes on the configuration port.
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    // Header constants.
    localparam logic [7:0]  BCAST_BYTE   = 8'hFF;
    localparam logic [7:0]  ETHTYPE_HI   = 8'h08;
    localparam logic [7:0]  VER_IHL      = 8'h45;
    localparam logic [7:0]  TTL_VALUE    = 8'd64;
    localparam logic [15:0] VER_IHL_WORD = 16'h4500;
    localparam logic [15:0] TTL_WORD     = 16'h4000;
    localparam logic [31:0] OWN_IP_RESET = 32'd167772687;

    // Kinds of command handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_HDR,
        CMD_DATA,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;
        logic               last;
        logic [31:0]        dst;
        logic [7:0]         proto;
        logic [15:0]        ip_len;
        logic [SUM_W-1:0]   sum;
    } cmd_t;

    // One step of the ones' complement end-around fold.
    function automatic logic [SUM_W-1:0] fold_sum(input logic [SUM_W-1:0] s);
        fold_sum = {4'd0, s[15:0]} + {16'd0, s[SUM_W-1:16]};
    endfunction

endpackage

### sv/ifb_front.sv
// Front end: accepts requests, checks the frame size and tracks the open frame.
module ifb_front
    import ifb_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] dst_addr,
    input  logic [7:0]  protocol,
    input  logic [15:0] payload_len,
    input  logic [7:0]  payload_byte,
    input  logic [31:0] own_ip,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        in_frame_reg, in_frame_next;
    logic        accept;
    logic [16:0] need_bytes;
    logic        oversize;
    logic [15:0] ip_len;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Size check without wrap, and the IPv4 total length.
    assign need_bytes = {1'b0, payload_len} + 17'(HDR_BYTES);
    assign oversize   = need_bytes > 17'(BUFFER_BYTES);
    assign ip_len     = payload_len + 16'(IP_HDR_BYTES);

    // Classify the request and build the command for the back end.
    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        in_frame_next     = in_frame_reg;
        q_push            = 1'b0;
        q_cmd.kind        = CMD_DATA;
        q_cmd.data        = payload_byte;
        q_cmd.last        = (bytes_left_reg == 16'd1);
        q_cmd.dst         = dst_addr;
        q_cmd.proto       = protocol;
        q_cmd.ip_len      = ip_len;
        // Unfolded header sum; the back end folds it while the header goes out.
        q_cmd.sum         = {4'd0, VER_IHL_WORD} + {4'd0, ip_len}
                          + {4'd0, TTL_WORD | {8'd0, protocol}}
                          + {4'd0, own_ip[31:16]} + {4'd0, own_ip[15:0]}
                          + {4'd0, dst_addr[31:16]} + {4'd0, dst_addr[15:0]};
        if (accept)
        begin
            if (action)
            begin
                if (in_frame_reg)
                begin
                    q_push          = 1'b1;
                    bytes_left_next = bytes_left_reg - 16'd1;
                    in_frame_next   = (bytes_left_reg != 16'd1);
                end
            end
            else
            begin
                q_push          = 1'b1;
                bytes_left_next = '0;
                in_frame_next   = 1'b0;
                if (oversize)
                begin
                    q_cmd.kind = CMD_ERR;
                    q_cmd.data = '0;
                    q_cmd.last = 1'b1;
                end
                else
                begin
                    q_cmd.kind = CMD_HDR;
                    q_cmd.last = (payload_len == 16'd0);
                    if (payload_len != 16'd0)
                    begin
                        bytes_left_next = payload_len;
                        in_frame_next   = 1'b1;
                    end
                end
            end
        end
    end

    // Frame tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            in_frame_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            in_frame_reg   <= in_frame_next;
        end
    end

endmodule

### sv/ifb_queue.sv
// Short command queue between the front and back ends.
module ifb_queue
    import ifb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head_cmd
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]      count_reg, count_next;
    logic                 do_push, do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/ifb_back.sv
// Back end: serialises headers, passes payload and drives the output register.
module ifb_back
    import ifb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        q_head,
    output logic        q_pop,
    input  logic [31:0] own_ip,
    input  logic [47:0] own_mac,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last,
    output logic        error
);

    localparam logic [5:0] CNT_LAST = 6'(HDR_BYTES - 1);

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             error_reg, error_next;
    logic             busy_reg, busy_next;
    logic [5:0]       cnt_reg, cnt_next;
    cmd_t             hdr_reg;
    logic             load_hdr;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [15:0]      csum;
    logic [7:0]       hdr_byte;
    logic             adv;

    assign adv  = !out_valid_reg || out_ready;
    assign csum = ~sum_reg[15:0];

    // Header byte selected by the position counter.
    always_comb
    begin
        unique case (cnt_reg)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: hdr_byte = BCAST_BYTE;
            6'd6:  hdr_byte = own_mac[47:40];
            6'd7:  hdr_byte = own_mac[39:32];
            6'd8:  hdr_byte = own_mac[31:24];
            6'd9:  hdr_byte = own_mac[23:16];
            6'd10: hdr_byte = own_mac[15:8];
            6'd11: hdr_byte = own_mac[7:0];
            6'd12: hdr_byte = ETHTYPE_HI;
            6'd14: hdr_byte = VER_IHL;
            6'd16: hdr_byte = hdr_reg.ip_len[15:8];
            6'd17: hdr_byte = hdr_reg.ip_len[7:0];
            6'd22: hdr_byte = TTL_VALUE;
            6'd23: hdr_byte = hdr_reg.proto;
            6'd24: hdr_byte = csum[15:8];
            6'd25: hdr_byte = csum[7:0];
            6'd26: hdr_byte = own_ip[31:24];
            6'd27: hdr_byte = own_ip[23:16];
            6'd28: hdr_byte = own_ip[15:8];
            6'd29: hdr_byte = own_ip[7:0];
            6'd30: hdr_byte = hdr_reg.dst[31:24];
            6'd31: hdr_byte = hdr_reg.dst[23:16];
            6'd32: hdr_byte = hdr_reg.dst[15:8];
            6'd33: hdr_byte = hdr_reg.dst[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    // Output sequencing: finish the header in progress, else take the next command.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        byte_next      = byte_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        q_pop          = 1'b0;
        load_hdr       = 1'b0;
        // The running sum folds on every header cycle; two folds settle it.
        sum_next       = busy_reg ? fold_sum(sum_reg) : sum_reg;
        if (adv)
        begin
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                byte_next      = hdr_byte;
                last_next      = (cnt_reg == CNT_LAST) && hdr_reg.last;
                error_next     = 1'b0;
                cnt_next       = cnt_reg + 6'd1;
                busy_next      = (cnt_reg != CNT_LAST);
            end
            else if (!q_empty)
            begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                last_next      = q_head.last;
                unique case (q_head.kind)
                    CMD_HDR:
                    begin
                        byte_next  = BCAST_BYTE;
                        last_next  = 1'b0;
                        error_next = 1'b0;
                        busy_next  = 1'b1;
                        cnt_next   = 6'd1;
                        load_hdr   = 1'b1;
                        sum_next   = q_head.sum;
                    end
                    CMD_ERR:
                    begin
                        byte_next  = 8'h00;
                        error_next = 1'b1;
                    end
                    default:
                    begin
                        byte_next  = q_head.data;
                        error_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers of the output and of the header in progress.
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        error_reg <= error_next;
        sum_reg   <= sum_next;
        if (load_hdr)
        begin
            hdr_reg <= q_head;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last       = last_reg;
    assign error      = error_reg;

endmodule

### sv/ipv4_frame_builder.sv
// Latency: a request passes through the command queue into the output register
// when the queue is empty and no header is being sent; a header then streams
// out at one byte per cycle while out_ready holds.
// Throughput: one payload byte per cycle while neither side stalls; a good start
// request yields a 34-byte header from the single header serialiser in the back end.
// Reset: rst_n clears the queue, the frame state and the output valid at once;
// own_ip returns to 10.0.2.15 and own_mac to zero.
module ipv4_frame_builder
    import ifb_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] dst_addr,
    input  logic [7:0]  protocol,
    input  logic [15:0] payload_len,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last,
    output logic        error
);

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic        cfg_write;
    logic        q_full, q_push, q_pop, q_empty;
    cmd_t        q_cmd, q_head;

    // Configuration registers, eight bytes apart.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= OWN_IP_RESET;
            own_mac_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3])
            REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            default:     prdata = '0;
        endcase
    end

    ifb_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .dst_addr     (dst_addr),
        .protocol     (protocol),
        .payload_len  (payload_len),
        .payload_byte (payload_byte),
        .own_ip       (own_ip_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    ifb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (q_head)
    );

    ifb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .own_ip     (own_ip_reg),
        .own_mac    (own_mac_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last       (last),
        .error      (error)
    );

endmodule

### bench/ipv4_frame_builder_tb.sv
// Self-checking testbench of the IPv4 frame builder, with its own frame prediction.
module ipv4_frame_builder_tb
    import ifb_pkg::*;
;

    // Buffer size given to the block, and the frame layout it works to.
    localparam int unsigned FRAME_BUFFER = 2048;
    localparam int unsigned HEADER_LEN   = 34;
    localparam int unsigned IPV4_HDR_LEN = 20;
    localparam int unsigned MAX_PAYLOAD  = FRAME_BUFFER - HEADER_LEN;

    // Request kinds on the action input.
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Register values after reset.
    localparam logic [31:0] RESET_OWN_IP  = 32'd167772687;
    localparam logic [47:0] RESET_OWN_MAC = 48'd0;

    // Cycles allowed for a queued request that gives no output to clear.
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic        action;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] len;
        logic [7:0]  data;
    } frame_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last_flag;
        logic       err_flag;
    } frame_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = ACT_START;
    logic [31:0] dst_addr = '0;
    logic [7:0]  protocol = '0;
    logic [15:0] payload_len = '0;
    logic [7:0]  payload_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  frame_byte;
    logic        last;
    logic        error;

    // Predicted block state and the bytes still owed by the block.
    logic [31:0] model_ip = RESET_OWN_IP;
    logic [47:0] model_mac = RESET_OWN_MAC;
    logic [15:0] bytes_left = '0;
    logic        frame_open = 1'b0;
    frame_out_t  due_bytes[$];

    // Idling controls shared by the test tasks and the output process.
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;

    int mismatches = 0;
    int bytes_checked = 0;
    int frames_built = 0;
    int frames_rejected = 0;
    int payload_passed = 0;
    int cycle_count = 0;

    ipv4_frame_builder #(
        .BUFFER_BYTES (FRAME_BUFFER)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .dst_addr     (dst_addr),
        .protocol     (protocol),
        .payload_len  (payload_len),
        .payload_byte (payload_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .last         (last),
        .error        (error)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Reset is held at the start of the run only.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: a run that hangs is a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Work out the bytes that one accepted request must produce.
    task automatic predict_request(input frame_req_t r);
        logic [7:0]  hdr [0:HEADER_LEN-1];
        logic [15:0] ip_len;
        logic [31:0] sum;
        logic [15:0] csum;
        int          i;
        if (r.action == ACT_PAYLOAD)
        begin
            // A stray payload byte is dropped without a trace.
            if (!frame_open)
                return;
            bytes_left = bytes_left - 16'd1;
            due_bytes.push_back('{data: r.data, last_flag: (bytes_left == 0),
                                  err_flag: 1'b0});
            payload_passed++;
            if (bytes_left == 0)
                frame_open = 1'b0;
            return;
        end

        // A new start always closes whatever frame was open.
        frame_open = 1'b0;
        bytes_left = '0;
        if (HEADER_LEN + r.len > FRAME_BUFFER)
        begin
            due_bytes.push_back('{data: 8'h00, last_flag: 1'b1, err_flag: 1'b1});
            frames_rejected++;
            return;
        end

        // Header checksum: ones' complement sum, folded twice, then inverted.
        ip_len = 16'(IPV4_HDR_LEN + r.len);
        sum = 32'h4500 + ip_len + (32'h4000 | r.proto)
            + model_ip[31:16] + model_ip[15:0] + r.dst[31:16] + r.dst[15:0];
        sum = {16'd0, sum[15:0]} + (sum >> 16);
        sum = {16'd0, sum[15:0]} + (sum >> 16);
        csum = ~sum[15:0];

        // Ethernet header followed by the IPv4 header, all big-endian.
        for (i = 0; i < 6; i++)
        begin
            hdr[i]     = 8'hFF;
            hdr[6 + i] = model_mac[47 - 8 * i -: 8];
        end
        hdr[12] = 8'h08;
        hdr[13] = 8'h00;
        hdr[14] = 8'h45;
        hdr[15] = 8'h00;
        hdr[16] = ip_len[15:8];
        hdr[17] = ip_len[7:0];
        for (i = 18; i < 22; i++)
            hdr[i] = 8'h00;
        hdr[22] = 8'd64;
        hdr[23] = r.proto;
        hdr[24] = csum[15:8];
        hdr[25] = csum[7:0];
        for (i = 0; i < 4; i++)
        begin
            hdr[26 + i] = model_ip[31 - 8 * i -: 8];
            hdr[30 + i] = r.dst[31 - 8 * i -: 8];
        end

        for (i = 0; i < HEADER_LEN; i++)
            due_bytes.push_back('{data: hdr[i],
                                  last_flag: (r.len == 0 && i == HEADER_LEN - 1),
                                  err_flag: 1'b0});
        frames_built++;
        if (r.len != 0)
        begin
            bytes_left = r.len;
            frame_open = 1'b1;
        end
    endtask

    // Offer one request, after a random gap when tx_idle is set, and predict it once it is taken.
    task automatic send_request(input frame_req_t r);
        int gap;
        gap = tx_idle ? $urandom_range(15, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= r.action;
        dst_addr     <= r.dst;
        protocol     <= r.proto;
        payload_len  <= r.len;
        payload_byte <= r.data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(r);
    endtask

    // Start request with random addressing; unused fields are random too.
    function automatic frame_req_t start_req(input logic [15:0] len);
        frame_req_t r;
        r.action = ACT_START;
        r.dst    = $urandom;
        r.proto  = 8'($urandom_range(255, 0));
        r.len    = len;
        r.data   = 8'($urandom_range(255, 0));
        return r;
    endfunction

    function automatic frame_req_t payload_req(input logic [7:0] data);
        frame_req_t r;
        r.action = ACT_PAYLOAD;
        r.dst    = $urandom;
        r.proto  = 8'($urandom_range(255, 0));
        r.len    = 16'($urandom_range(65535, 0));
        r.data   = data;
        return r;
    endfunction

    // Stop offering requests and wait until every owed byte has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle; only while idle.
    task automatic write_register(input logic idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OWN_IP:  model_ip  = value[31:0];
            REG_OWN_MAC: model_mac = value[47:0];
            default: ;
        endcase
    endtask

    // Output side: random stalls, long hold-offs on demand, and the byte check.
    initial
    begin : output_side
        int         wait_cycles;
        frame_out_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_cycles = rx_hold + (rx_idle ? $urandom_range(15, 0) : 0);
            rx_hold = 0;
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (due_bytes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected output byte %02h last %0b error %0b",
                         $time, frame_byte, last, error);
            end
            else
            begin
                want = due_bytes.pop_front();
                bytes_checked++;
                if (frame_byte !== want.data)
                begin
                    mismatches++;
                    $display("%0t: frame_byte expected %02h actual %02h",
                             $time, want.data, frame_byte);
                end
                if (last !== want.last_flag)
                begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last_flag, last);
                end
                if (error !== want.err_flag)
                begin
                    mismatches++;
                    $display("%0t: error expected %0b actual %0b",
                             $time, want.err_flag, error);
                end
            end
        end
    end

    // Reset register values, an empty frame and a one-byte frame.
    task automatic test_default_registers();
        send_request(start_req(16'd0));
        send_request(start_req(16'd1));
        send_request(payload_req(8'hFF));
        drain();
    endtask

    // Register extremes, including the checksum carry with all-ones addresses.
    task automatic test_register_extremes();
        frame_req_t r;
        write_register(REG_OWN_IP, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF_FFFF);
        r = start_req(16'd2);
        r.dst   = 32'hFFFF_FFFF;
        r.proto = 8'hFF;
        send_request(r);
        send_request(payload_req(8'h00));
        send_request(payload_req(8'h5A));
        drain();
        write_register(REG_OWN_IP, 64'd0);
        write_register(REG_OWN_MAC, 64'd0);
        r = start_req(16'd0);
        r.dst   = 32'd0;
        r.proto = 8'h00;
        send_request(r);
        drain();
        write_register(REG_OWN_IP, 64'hC0A8_0A01);
        write_register(REG_OWN_MAC, 64'h0200_5E10_2030);
    endtask

    // Stray bytes, oversize starts, abandoned frames and the largest payload.
    task automatic test_special_cases();
        send_request(payload_req(8'h3C));
        send_request(start_req(16'(MAX_PAYLOAD + 1)));
        send_request(start_req(16'hFFFF));
        // A start while a frame is open abandons it.
        send_request(start_req(16'd5));
        send_request(payload_req(8'h11));
        send_request(payload_req(8'h22));
        send_request(start_req(16'd1));
        send_request(payload_req(8'h33));
        // An oversize start closes the open frame; later bytes are dropped.
        send_request(start_req(16'd3));
        send_request(payload_req(8'h44));
        send_request(start_req(16'(MAX_PAYLOAD + 1)));
        send_request(payload_req(8'h55));
        // Largest payload that still fits, cut short by an empty frame.
        send_request(start_req(16'(MAX_PAYLOAD)));
        send_request(payload_req(8'h66));
        send_request(payload_req(8'h77));
        send_request(payload_req(8'h88));
        send_request(start_req(16'd0));
        drain();
    endtask

    // Mostly whole frames with random content, plus cut-short frames, rejects and stray bytes.
    task automatic random_frames(input int count);
        int sent;
        int pick;
        int len;
        int nbytes;
        int j;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99, 0);
            tx_idle = ($urandom_range(3, 0) != 0);
            rx_idle = ($urandom_range(3, 0) != 0);
            if (pick < 10)
            begin
                send_request(payload_req(8'($urandom_range(255, 0))));
            end
            else if (pick < 22)
            begin
                send_request(start_req(16'($urandom_range(65535, MAX_PAYLOAD + 1))));
                sent++;
            end
            else
            begin
                len = (pick < 27) ? $urandom_range(120, 40) : $urandom_range(12, 0);
                nbytes = (pick < 35 && len > 0) ? $urandom_range(len - 1, 0) : len;
                send_request(start_req(16'(len)));
                sent++;
                for (j = 0; j < nbytes; j++)
                begin
                    send_request(payload_req(8'($urandom_range(255, 0))));
                    sent++;
                end
            end
        end
        drain();
    endtask

    // Two phases of random traffic under different register settings.
    task automatic test_random_traffic();
        random_frames(40);
        write_register(REG_OWN_IP, {$urandom, $urandom});
        write_register(REG_OWN_MAC, {$urandom, $urandom});
        random_frames(40);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Long output stall while requests keep coming, so the input stalls too.
    task automatic test_backpressure();
        int j;
        tx_idle = 1'b0;
        rx_hold = 200;
        for (j = 0; j < 6; j++)
            send_request(start_req(16'd0));
        send_request(start_req(16'd6));
        for (j = 0; j < 6; j++)
            send_request(payload_req(8'($urandom_range(255, 0))));
        drain();
        tx_idle = 1'b1;
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        test_default_registers();
        test_register_extremes();
        test_special_cases();
        test_random_traffic();
        test_backpressure();
        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d frames, %0d oversize rejects and %0d payload bytes,",
                 frames_built, frames_rejected, payload_passed);
        $display("under several register settings and heavy stalls: %0d bytes checked.",
                 bytes_checked);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
